// File: rtl/lru_pft_pkg.sv
// ============================================================================
// LRU page frame tracker package
// Shared constants and the search and update structs passed between the
// tracker top level and its frame cells.
// ============================================================================
package lru_pft_pkg;

    localparam int MAX_FRAMES_DEF = 8;
    localparam int PAGE_BITS_DEF  = 16;

    // Frame indexes and ranks travel at the width that covers the largest
    // supported frame count (64 frames).
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 4;
    localparam int FIDX_W  = 3;
    localparam int FAULT_W = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd8;

    // Running result of the lookup as it walks down the row of frame cells.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [IDX_W-1:0] hit_rank;
        logic             empty;
        logic [IDX_W-1:0] empty_idx;
        logic [IDX_W-1:0] max_rank;
        logic [IDX_W-1:0] max_idx;
    } srch_t;

    // Update broadcast to every cell once the lookup has finished.
    typedef struct packed {
        logic             en;
        logic             clear;
        logic             load;
        logic             was_valid;
        logic [IDX_W-1:0] slot;
        logic [IDX_W-1:0] ref_rank;
    } upd_t;

endpackage

// File: rtl/lru_pft_cell.sv
// ============================================================================
// LRU page frame cell
// Holds one page frame (page, valid bit, recency rank), folds its own state
// into the passing lookup and applies the broadcast recency update.
// ============================================================================
module lru_pft_cell #(
    parameter int MAX_FRAMES = lru_pft_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lru_pft_pkg::PAGE_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [lru_pft_pkg::CFG_W-1:0]  frames_in_use,
    input  logic [PAGE_BITS-1:0]           page,
    input  lru_pft_pkg::upd_t              upd,
    input  lru_pft_pkg::srch_t             srch_in,
    output lru_pft_pkg::srch_t             srch_out
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
    localparam logic [lru_pft_pkg::IDX_W-1:0] MY_IDX = lru_pft_pkg::IDX_W'(CELL_IDX);

    logic [PAGE_BITS-1:0]              page_reg;
    logic                              valid_reg;
    logic [RANK_W-1:0]                 rank_reg;
    logic [lru_pft_pkg::IDX_W-1:0]     rank_ext;
    logic                              active;
    lru_pft_pkg::srch_t                srch_next;
    lru_pft_pkg::srch_t                srch_reg;

    // Frame zero always takes part; the others only below the frame count.
    assign active   = (CELL_IDX == 0) || (int'(frames_in_use) > CELL_IDX);
    assign rank_ext = lru_pft_pkg::IDX_W'(rank_reg);
    assign srch_out = srch_reg;

    always_comb begin
        srch_next = srch_in;
        if (srch_in.vld && active) begin
            if (valid_reg && (page_reg == page) && !srch_in.hit) begin
                srch_next.hit      = 1'b1;
                srch_next.hit_idx  = MY_IDX;
                srch_next.hit_rank = rank_ext;
            end
            if (!valid_reg && !srch_in.empty) begin
                srch_next.empty     = 1'b1;
                srch_next.empty_idx = MY_IDX;
            end
            // Strict compare keeps the lowest-numbered frame among equal ranks.
            if (rank_ext > srch_in.max_rank) begin
                srch_next.max_rank = rank_ext;
                srch_next.max_idx  = MY_IDX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            srch_reg  <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end else begin
            srch_reg <= srch_next;
            if (upd.en) begin
                if (upd.clear) begin
                    valid_reg <= 1'b0;
                    rank_reg  <= '0;
                end else if (upd.slot == MY_IDX) begin
                    valid_reg <= 1'b1;
                    rank_reg  <= '0;
                end else if (active && valid_reg &&
                             (!upd.was_valid || (rank_ext < upd.ref_rank)) &&
                             (rank_reg != RANK_MAX)) begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.en && upd.load && (upd.slot == MY_IDX)) begin
            page_reg <= page;
        end
    end

endmodule

// File: rtl/lru_page_frame_tracker.sv
// ============================================================================
// LRU page frame tracker
// Fully associative page frame set with least-recently-used replacement,
// built as a row of frame cells that a lookup walks through one per cycle.
// ============================================================================
//
//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+------------------------------------
//  cfg      | in        | cfg_we            | cfg_wdata: frames_in_use
//  s_       | in        | s_tvalid/s_tready | s_tdata: page_number; s_tlast: last
//  m_       | out       | m_tvalid/m_tready | m_tdata: frame_index, fault_total;
//           |           |                   | m_tuser: page_fault
//
//  After acceptance a transfer runs a launch step, walks down the cell row
//  frame cell by frame cell, and then applies the update; s_tready rises
//  again once the update has been applied.
//  Reset (aresetn low, synchronous) empties all frames, clears the fault
//  count and sets the frame count to eight.
//  A result waits in the output register while the next lookup proceeds;
//  only the update step stalls until that register has been taken.
//
module lru_page_frame_tracker #(
    parameter int MAX_FRAMES = lru_pft_pkg::MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = lru_pft_pkg::PAGE_BITS_DEF,
    parameter int IN_W       = ((PAGE_BITS + 7) / 8) * 8,
    parameter int OUT_W      = ((lru_pft_pkg::FIDX_W + lru_pft_pkg::FAULT_W + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_we,
    input  logic [lru_pft_pkg::CFG_W-1:0] cfg_wdata,   // frames_in_use

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,     // page_number, zero padded
    input  logic                          s_tlast,     // last_in_sequence

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,     // frame_index, fault_total, zero padded
    output logic [0:0]                    m_tuser      // page_fault
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t                              state_reg;
    logic [lru_pft_pkg::CFG_W-1:0]       cfg_reg;
    logic [PAGE_BITS-1:0]                page_reg;
    logic                                last_reg;
    lru_pft_pkg::srch_t                  res_reg;
    logic [lru_pft_pkg::FAULT_W-1:0]     fault_reg;
    logic [lru_pft_pkg::FAULT_W-1:0]     fault_next;
    logic                                m_tvalid_reg;
    logic                                fault_out_reg;
    logic [lru_pft_pkg::FIDX_W-1:0]      fidx_out_reg;
    logic [lru_pft_pkg::FAULT_W-1:0]     total_out_reg;

    lru_pft_pkg::srch_t                  chain [MAX_FRAMES+1];
    lru_pft_pkg::upd_t                   upd;

    logic                                miss;
    logic                                was_valid;
    logic [lru_pft_pkg::IDX_W-1:0]       slot;
    logic [lru_pft_pkg::IDX_W-1:0]       ref_rank;
    logic                                fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({total_out_reg, fidx_out_reg});
    assign m_tuser  = fault_out_reg;

    // The lookup enters the first cell with nothing found yet. The initial
    // oldest candidate is frame zero with rank zero, which is always active.
    always_comb begin
        chain[0]     = '0;
        chain[0].vld = (state_reg == ST_LAUNCH);
    end

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lru_pft_cell #(
            .MAX_FRAMES (MAX_FRAMES),
            .PAGE_BITS  (PAGE_BITS),
            .CELL_IDX   (g)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .frames_in_use (cfg_reg),
            .page          (page_reg),
            .upd           (upd),
            .srch_in       (chain[g]),
            .srch_out      (chain[g+1])
        );
    end

    // Pick the frame from the finished lookup. A hit refreshes its frame; a
    // miss fills the lowest empty frame, or else evicts the oldest one. When
    // an empty frame is filled every other active valid frame ages by one.
    always_comb begin
        if (res_reg.hit) begin
            miss      = 1'b0;
            was_valid = 1'b1;
            slot      = res_reg.hit_idx;
            ref_rank  = res_reg.hit_rank;
        end else if (res_reg.empty) begin
            miss      = 1'b1;
            was_valid = 1'b0;
            slot      = res_reg.empty_idx;
            ref_rank  = '0;
        end else begin
            miss      = 1'b1;
            was_valid = 1'b1;
            slot      = res_reg.max_idx;
            ref_rank  = res_reg.max_rank;
        end
    end

    // The update step runs once the output register is free to take the result.
    assign fire = (state_reg == ST_UPDATE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        upd.en        = fire;
        upd.clear     = last_reg;
        upd.load      = miss;
        upd.was_valid = was_valid;
        upd.slot      = slot;
        upd.ref_rank  = ref_rank;
    end

    // The fault count saturates at all ones.
    assign fault_next = (miss && (fault_reg != '1)) ? fault_reg + 1'b1 : fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_reg      <= lru_pft_pkg::FRAMES_RESET;
            fault_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
            // A new result loaded by the update step keeps the register full.
            if (m_tvalid_reg && m_tready && !fire) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        page_reg  <= s_tdata[PAGE_BITS-1:0];
                        last_reg  <= s_tlast;
                        state_reg <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH: begin
                    if (chain[MAX_FRAMES].vld) begin
                        res_reg   <= chain[MAX_FRAMES];
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (fire) begin
                        m_tvalid_reg  <= 1'b1;
                        fault_out_reg <= miss;
                        fidx_out_reg  <= slot[lru_pft_pkg::FIDX_W-1:0];
                        total_out_reg <= fault_next;
                        // A last transfer reports its count, then starts over.
                        fault_reg     <= last_reg ? '0 : fault_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
